// ----- src/lsp_pkg.sv -----
// Package for the leg swing phase tracker: constants, codes and payload types.
package lsp_pkg;

  localparam int NUM_LEGS       = 4;
  localparam int SCHEDULE_SLOTS = 16;
  localparam int MASK_W         = 16;
  localparam int SLOT_W         = $clog2(SCHEDULE_SLOTS + 1);
  localparam int LEG_ADDR_W     = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;
  localparam int PROG_FRAC      = 15;
  localparam int DIV_CNT_W      = $clog2(PROG_FRAC);
  localparam logic [15:0] Q_ONE = 16'h8000;
  localparam logic [15:0] MAX_PROG_RESET = 16'h4000;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_TICK     = 2'd1,
    OP_TARGET   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    PH_NOT_STARTED = 2'd0,
    PH_STANCE      = 2'd1,
    PH_SWINGING    = 2'd2,
    PH_REACHED     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    INIT_KEEP = 2'd0,
    INIT_FOOT = 2'd1,
    INIT_SLOT = 2'd2
  } init_src_e;

  typedef enum logic [1:0] {
    EVAL_NONE     = 2'd0,
    EVAL_ZERO     = 2'd1,
    EVAL_PROGRESS = 2'd2,
    EVAL_END      = 2'd3
  } eval_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } lsp_state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [1:0]        leg;
    logic [31:0]       now_time;
    logic [MASK_W-1:0] contact_mask;
    logic [31:0]       schedule_time;
    logic [31:0]       swing_duration;
    logic [31:0]       swing_remaining;
  } lsp_in_t;

  typedef struct packed {
    logic [1:0]        leg_out;
    logic [1:0]        phase;
    logic [15:0]       progress;
    logic [SLOT_W-1:0] flight_start;
    logic [SLOT_W-1:0] flight_end;
    logic [1:0]        initial_source;
    logic              retarget;
    logic              refresh_shape;
    logic [1:0]        eval_mode;
  } lsp_out_t;

  // One leg's record in the state memory.
  typedef struct packed {
    phase_e      phase;
    logic [15:0] progress;
    logic [31:0] planned;
    logic [31:0] remaining;
  } lsp_entry_t;

  localparam lsp_entry_t ENTRY_RESET = '{
    phase:     PH_STANCE,
    progress:  16'd0,
    planned:   32'd0,
    remaining: 32'd0
  };

endpackage

// ----- src/lsp_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
module lsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/leg_swing_phase_tracker.sv -----
// Top level of the leg swing phase tracker: sequencer, state memory and progress divider.

// Each accepted item concerns one leg and is a gait schedule update, a time
// tick or a target request; it produces exactly one result, except items with
// the unused opcode, which are taken and dropped without effect. The per-leg
// phase, progress and swing timing live in a four-entry synchronous memory that
// is read when an item is taken and written back when its result is loaded, so
// only one item is in flight at a time and in_stall_o is high while it is.
// A target request passes through the read and done states before it reaches
// the result register, a schedule update or time tick that needs no division
// through read, calc and done, and one that does through the divide state as
// well: the progress quotient comes from a restoring divider that settles one
// of its 15 fraction bits per cycle. The input is free again as soon as
// the result is loaded. A result that waits in the output register while
// out_stall_i is high holds back the write-back of the next item, not its
// transfer. After reset every leg reads as in stance with zero timing;
// per-leg valid flags stand in for the memory until a leg is first written,
// so no clearing pass is needed. The retarget threshold register may be
// written at any time the block is idle and takes effect on the next item.
module leg_swing_phase_tracker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  lsp_pkg::lsp_in_t         in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output lsp_pkg::lsp_out_t        out_data_o,
  input  logic                     cfg_wr_en_i,
  input  logic [15:0]              cfg_wr_data_i
);

  import lsp_pkg::*;

  // Sequencer and working registers.
  lsp_state_e            state_q, state_d;
  lsp_in_t               item_q, item_d;
  phase_e                ph_q, ph_d;
  eval_mode_e            eval_q, eval_d;
  logic [15:0]           prog_q, prog_d;
  logic [31:0]           planned_q, planned_d;
  logic [31:0]           remain_q, remain_d;
  logic [31:0]           since_q, since_d;
  logic [SLOT_W-1:0]     fs_q, fs_d;
  logic [SLOT_W-1:0]     fe_q, fe_d;

  // Progress divider.
  logic [31:0]           div_rem_q, div_rem_d;
  logic [PROG_FRAC-1:0]  div_quot_q, div_quot_d;
  logic [DIV_CNT_W-1:0]  div_cnt_q, div_cnt_d;

  // Architectural registers outside the memory.
  logic [31:0]           stamp_q, stamp_d;
  logic [15:0]           max_prog_q;
  logic [NUM_LEGS-1:0]   leg_valid_q, leg_valid_d;

  // Output register.
  logic                  out_valid_q, out_valid_d;
  lsp_out_t              out_data_q, out_data_d;

  // Memory ports.
  logic                  ram_re, ram_we;
  logic [LEG_ADDR_W-1:0] ram_raddr, ram_waddr;
  lsp_entry_t            ram_rdata, ram_wdata;

  logic                  accept;
  logic                  out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign ram_raddr   = LEG_ADDR_W'(in_data_i.leg);
  assign ram_waddr   = LEG_ADDR_W'(item_q.leg);

  lsp_ram #(
    .WIDTH ($bits(lsp_entry_t)),
    .DEPTH (NUM_LEGS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q     <= '0;
      max_prog_q  <= MAX_PROG_RESET;
      leg_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stamp_q     <= stamp_d;
      leg_valid_q <= leg_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr_en_i) begin
        max_prog_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    ph_q       <= ph_d;
    eval_q     <= eval_d;
    prog_q     <= prog_d;
    planned_q  <= planned_d;
    remain_q   <= remain_d;
    since_q    <= since_d;
    fs_q       <= fs_d;
    fe_q       <= fe_d;
    div_rem_q  <= div_rem_d;
    div_quot_q <= div_quot_d;
    div_cnt_q  <= div_cnt_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    logic [SCHEDULE_SLOTS-1:0] slot_mask;
    logic [SLOT_W-1:0]         slot_s;
    logic [SLOT_W-1:0]         slot_e;
    lsp_entry_t                entry;
    phase_e                    ph_upd;
    logic [31:0]               stamp_eff;
    logic signed [34:0]        elapsed;
    logic [32:0]               shifted;
    logic [32:0]               trial;
    logic [PROG_FRAC-1:0]      quot_next;
    logic                      ret;

    state_d     = state_q;
    item_d      = item_q;
    ph_d        = ph_q;
    eval_d      = eval_q;
    prog_d      = prog_q;
    planned_d   = planned_q;
    remain_d    = remain_q;
    since_d     = since_q;
    fs_d        = fs_q;
    fe_d        = fe_q;
    div_rem_d   = div_rem_q;
    div_quot_d  = div_quot_q;
    div_cnt_d   = div_cnt_q;
    stamp_d     = stamp_q;
    leg_valid_d = leg_valid_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = '{phase: ph_q, progress: prog_q, planned: planned_q, remaining: remain_q};
    ph_upd      = ph_q;
    stamp_eff   = stamp_q;

    // Flight window search; slots past the end of the mask count as no contact.
    slot_mask = SCHEDULE_SLOTS'(item_q.contact_mask);
    slot_s    = SLOT_W'(SCHEDULE_SLOTS);
    for (int i = SCHEDULE_SLOTS - 1; i >= 0; i--) begin
      if (!slot_mask[i]) begin
        slot_s = SLOT_W'(i);
      end
    end
    slot_e = SLOT_W'(SCHEDULE_SLOTS);
    for (int i = SCHEDULE_SLOTS - 1; i >= 0; i--) begin
      if (slot_mask[i] && (SLOT_W'(i) >= slot_s)) begin
        slot_e = SLOT_W'(i);
      end
    end

    // A leg that was never written reads as its reset record.
    entry = leg_valid_q[ram_waddr] ? ram_rdata : ENTRY_RESET;

    elapsed = $signed({3'b000, planned_q}) - $signed({3'b000, remain_q})
            + $signed({3'b000, since_q});

    shifted   = {div_rem_q, 1'b0};
    trial     = shifted - {1'b0, planned_q};
    quot_next = {div_quot_q[PROG_FRAC-2:0], (shifted >= {1'b0, planned_q})};

    ret = (fe_q != SLOT_W'(SCHEDULE_SLOTS)) &&
          ((ph_q == PH_NOT_STARTED) || (ph_q == PH_STANCE) ||
           ((ph_q == PH_SWINGING) && (prog_q <= max_prog_q)));

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          item_d = in_data_i;
          if ((in_data_i.opcode inside {OP_SCHEDULE, OP_TICK, OP_TARGET}) &&
              (int'(in_data_i.leg) < NUM_LEGS)) begin
            ram_re  = 1'b1;
            state_d = ST_READ;
          end
        end
      end

      ST_READ: begin
        ph_upd    = entry.phase;
        planned_d = entry.planned;
        remain_d  = entry.remaining;
        prog_d    = entry.progress;
        stamp_eff = stamp_q;
        eval_d    = EVAL_NONE;
        fs_d      = slot_s;
        fe_d      = slot_e;
        if (item_q.opcode == OP_SCHEDULE) begin
          if (slot_s != '0) begin
            ph_upd = PH_STANCE;
          end else if (entry.phase == PH_STANCE) begin
            ph_upd = PH_NOT_STARTED;
          end
          planned_d = item_q.swing_duration;
          remain_d  = item_q.swing_remaining;
          stamp_eff = item_q.schedule_time;
        end
        since_d = item_q.now_time - stamp_eff;
        if (item_q.opcode == OP_TARGET) begin
          case (entry.phase)
            PH_NOT_STARTED, PH_SWINGING: begin
              eval_d = EVAL_PROGRESS;
              ph_upd = PH_SWINGING;
            end
            PH_REACHED: eval_d = EVAL_END;
            default:    eval_d = EVAL_ZERO;
          endcase
          state_d = ST_DONE;
        end else begin
          state_d = ST_CALC;
        end
        ph_d = ph_upd;
      end

      ST_CALC: begin
        state_d = ST_DONE;
        if ((ph_q == PH_NOT_STARTED) || (ph_q == PH_SWINGING)) begin
          if ((planned_q == '0) || (elapsed >= $signed({3'b000, planned_q}))) begin
            ph_d   = PH_REACHED;
            prog_d = Q_ONE;
          end else if (elapsed <= 0) begin
            prog_d = '0;
          end else begin
            // Here 0 < elapsed < planned, so it fits in 32 bits.
            div_rem_d  = elapsed[31:0];
            div_quot_d = '0;
            div_cnt_d  = '0;
            state_d    = ST_DIV;
          end
        end else begin
          prog_d = '0;
        end
      end

      ST_DIV: begin
        if (shifted >= {1'b0, planned_q}) begin
          div_rem_d = trial[31:0];
        end else begin
          div_rem_d = shifted[31:0];
        end
        div_quot_d = quot_next;
        div_cnt_d  = div_cnt_q + 1'b1;
        if (div_cnt_q == DIV_CNT_W'(PROG_FRAC - 1)) begin
          prog_d  = 16'(quot_next);
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (out_free) begin
          ram_we                 = 1'b1;
          leg_valid_d[ram_waddr] = 1'b1;
          if (item_q.opcode == OP_SCHEDULE) begin
            stamp_d = item_q.schedule_time;
          end
          out_valid_d               = 1'b1;
          out_data_d                = '0;
          out_data_d.leg_out        = item_q.leg;
          out_data_d.phase          = ph_q;
          out_data_d.progress       = prog_q;
          out_data_d.initial_source = INIT_KEEP;
          out_data_d.eval_mode      = EVAL_NONE;
          case (item_q.opcode)
            OP_SCHEDULE: begin
              out_data_d.flight_start  = fs_q;
              out_data_d.flight_end    = fe_q;
              out_data_d.refresh_shape = (ph_q == PH_STANCE);
              out_data_d.retarget      = ret;
              if (ph_q == PH_NOT_STARTED) begin
                out_data_d.initial_source = INIT_FOOT;
              end else if (ph_q == PH_STANCE) begin
                out_data_d.initial_source = INIT_SLOT;
              end
            end
            OP_TICK: begin
              if (ph_q == PH_NOT_STARTED) begin
                out_data_d.initial_source = INIT_FOOT;
              end
            end
            default: begin
              out_data_d.eval_mode = eval_q;
            end
          endcase
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // A leg in stance always carries zero progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.phase == PH_STANCE)) |-> (out_data_o.progress == '0))
    else $error("stance result with nonzero progress");

  // Progress never exceeds one in Q1.15.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.progress <= Q_ONE))
    else $error("progress above one");

  // The restoring divider keeps its partial remainder below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_rem_q < planned_q))
    else $error("divider remainder out of range");

  // Nothing is written back while an earlier result still waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (!$past(out_valid_o) || out_free))
    else $error("write-back while output register is held");

endmodule
